// ----- src/ddt_pkg.sv -----
package ddt_pkg;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRE_DELAY    = 2'd0,
		REG_DEBOUNCE_TIME = 2'd1,
		REG_STEP_LENGTH   = 2'd2,
		REG_ONE_SHOT      = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_UNINIT   = 3'd0,
		ST_EVAL     = 3'd1,
		ST_DELAY    = 3'd2,
		ST_FIRE     = 3'd3,
		ST_DEBOUNCE = 3'd4,
		ST_DEAD     = 3'd5
	} fire_state_t;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_ARM  = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] current_time;
		logic        predicate;
	} item_t;

	typedef struct packed {
		logic [2:0] fire_state;
		logic       firing;
	} result_t;

	typedef struct packed {
		logic [15:0] fire_delay;
		logic [31:0] debounce_time;
		logic [31:0] step_length;
		logic        one_shot;
	} cfg_t;

endpackage

// ----- src/ddt_fsm.sv -----
// Trigger state machine: state and start-time registers plus next-state logic.
module ddt_fsm #(
	parameter int TIME_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  ddt_pkg::item_t  item,
	input  ddt_pkg::cfg_t   cfg,
	output ddt_pkg::result_t result
);

	ddt_pkg::fire_state_t state_q, state_d;
	logic [TIME_WIDTH-1:0] pred_start_q, pred_start_d;
	logic [TIME_WIDTH-1:0] deb_start_q, deb_start_d;

	logic [TIME_WIDTH-1:0] now;
	logic [TIME_WIDTH-1:0] pred_el;
	logic [TIME_WIDTH-1:0] deb_el;
	logic                  deb_el_hi_nz;
	logic [63:0]           deb_prod;
	logic                  deb_done;

	assign now     = TIME_WIDTH'(item.current_time);
	assign pred_el = now - pred_start_q;
	assign deb_el  = now - deb_start_q;

	// elapsed * step > D; D fits 32 bits, so any elapsed bit above 32 with a
	// nonzero step already wins
	assign deb_el_hi_nz = (deb_el >> 32) != '0;
	assign deb_prod     = 64'(32'(deb_el)) * 64'(cfg.step_length);
	assign deb_done     = (cfg.step_length != '0) &&
		(deb_el_hi_nz || (deb_prod > 64'(cfg.debounce_time)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ddt_pkg::ST_UNINIT;
			pred_start_q <= '0;
			deb_start_q  <= '0;
		end else if (advance) begin
			state_q      <= state_d;
			pred_start_q <= pred_start_d;
			deb_start_q  <= deb_start_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		pred_start_d = pred_start_q;
		deb_start_d  = deb_start_q;
		if (item.action == ddt_pkg::ACT_ARM) begin
			state_d      = ddt_pkg::ST_EVAL;
			pred_start_d = '0;
			deb_start_d  = '0;
		end else begin
			unique case (state_q)
				ddt_pkg::ST_EVAL: begin
					if (item.predicate) begin
						if (cfg.fire_delay != '0) begin
							pred_start_d = now;
							state_d      = ddt_pkg::ST_DELAY;
						end else begin
							state_d = ddt_pkg::ST_FIRE;
						end
					end
				end
				ddt_pkg::ST_DELAY: begin
					if (pred_el > TIME_WIDTH'(cfg.fire_delay)) begin
						state_d = ddt_pkg::ST_FIRE;
					end
				end
				ddt_pkg::ST_FIRE: begin
					priority if (cfg.one_shot) begin
						state_d = ddt_pkg::ST_DEAD;
					end else if (cfg.debounce_time != '0) begin
						deb_start_d = now;
						state_d     = ddt_pkg::ST_DEBOUNCE;
					end else begin
						state_d = ddt_pkg::ST_EVAL;
					end
				end
				ddt_pkg::ST_DEBOUNCE: begin
					if (deb_done) begin
						state_d = ddt_pkg::ST_EVAL;
					end
				end
				default: begin
					// uninit, dead and unused codes hold
					state_d = state_q;
				end
			endcase
		end
	end

	assign result.fire_state = state_d;
	assign result.firing     = (state_d == ddt_pkg::ST_FIRE);

endmodule

// ----- src/delayed_debounced_trigger_fsm_core.sv -----
// An accepted item beat waits in the input register and moves into the result
// register, raising result_valid, once that register is empty or being taken.
// Throughput: one item per cycle while result_stall is low; the state update
// for an item happens as it moves from the input register into the result
// register; the longest path is the subtract, 32x32 multiply and compare of
// the debounce check. Reset: arst_n clears state to uninitialized, both start
// times and all configuration registers to zero, and drops both valid flags.
module delayed_debounced_trigger_fsm_core #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// item channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  ddt_pkg::item_t                      item,

	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output ddt_pkg::result_t                    result,

	// configuration writes
	input  logic                                cfg_we,
	input  logic [ddt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ddt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// configuration registers
	ddt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (ddt_pkg::cfg_reg_t'(cfg_index))
				ddt_pkg::REG_FIRE_DELAY:    cfg_q.fire_delay    <= cfg_data[15:0];
				ddt_pkg::REG_DEBOUNCE_TIME: cfg_q.debounce_time <= cfg_data;
				ddt_pkg::REG_STEP_LENGTH:   cfg_q.step_length   <= cfg_data;
				ddt_pkg::REG_ONE_SHOT:      cfg_q.one_shot      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register (stage 1) and result register (stage 2)
	logic             item_valid_s1;
	ddt_pkg::item_t   item_s1;
	logic             res_valid_s2;
	ddt_pkg::result_t res_s2;
	ddt_pkg::result_t res_next;
	logic             advance;
	logic             in_take;

	// stage 1 drains whenever the result register is empty or being taken
	assign advance    = item_valid_s1 && (!res_valid_s2 || !result_stall);
	assign item_stall = item_valid_s1 && !advance;
	assign in_take    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_take) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item;
		end
	end

	// state update is committed only when the beat moves on
	ddt_fsm #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.result  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid = res_valid_s2;
	assign result       = res_s2;

endmodule
